/* src/mouse_look_direction_defines.svh */
// Assertion macros for the mouse-look direction block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MOUSE_LOOK_DIRECTION_DEFINES_SVH
`define MOUSE_LOOK_DIRECTION_DEFINES_SVH

`ifndef SYNTHESIS
`define MLD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mouse_look_direction assertion failed");
`define MLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mouse_look_direction assertion failed");
`else
`define MLD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define MLD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/mld_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for mouse_look_direction.
// No dependencies.
package mld_pkg;

	localparam int ANGLE_FRAC_BITS = 16;
	localparam int YAW_W           = 25;
	localparam int PITCH_W         = 24;
	localparam int SENS_W          = 16;
	localparam int LIMIT_W         = 23;
	localparam int CFG_DATA_W      = 23;
	localparam int CFG_INDEX_W     = 2;
	localparam int ATAN_IDX_W      = 5;
	localparam int XY_W            = 32;
	localparam int XY_FRAC         = 30;
	localparam int Z_W             = 34;
	localparam int Z_FRAC          = 24;

	localparam int DEG90  = 90 <<< ANGLE_FRAC_BITS;
	localparam int DEG180 = 180 <<< ANGLE_FRAC_BITS;
	localparam int DEG360 = 360 <<< ANGLE_FRAC_BITS;

	localparam int YAW_RESET   = -(90 <<< ANGLE_FRAC_BITS);
	localparam int SENS_RESET  = 3277;
	localparam int LIMIT_RESET = 89 <<< ANGLE_FRAC_BITS;

	localparam logic signed [XY_W-1:0] CORDIC_INV_GAIN = 32'sd652032874;
	localparam logic signed [Z_W-1:0]  NINETY_Z        = Z_W'(64'sd90 <<< Z_FRAC);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SENSITIVITY = 2'd0,
		CFG_PITCH_LIMIT = 2'd1
	} mld_cfg_idx_t;

	typedef struct packed {
		logic [SENS_W-1:0]  sensitivity;
		logic [LIMIT_W-1:0] pitch_limit;
	} mld_cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_SCALE_X,
		OP_SCALE_Y,
		OP_SAT_Y,
		OP_ANGLE,
		OP_CORDIC_YAW,
		OP_CORDIC_PITCH,
		OP_CORDIC_STEP,
		OP_SAVE_YAW,
		OP_SAVE_PITCH,
		OP_MUL_X,
		OP_MUL_Z,
		OP_ROUND_X,
		OP_ROUND_Y,
		OP_ROUND_Z
	} mld_op_t;

	typedef struct packed {
		mld_op_t                 op;
		logic [ATAN_IDX_W-1:0]   step;
		logic                    publish;
	} mld_cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SCALE_X,
		ST_SCALE_Y,
		ST_SAT_Y,
		ST_ANGLE,
		ST_YAW_INIT,
		ST_YAW_ITER,
		ST_YAW_SAVE,
		ST_PITCH_INIT,
		ST_PITCH_ITER,
		ST_PITCH_SAVE,
		ST_MUL_X,
		ST_ROUND_X,
		ST_MUL_Z,
		ST_ROUND_Z,
		ST_ROUND_Y,
		ST_PUBLISH
	} mld_state_t;

	// atan(2^-i) in degrees, Q24
	function automatic logic signed [31:0] atan_q24(input logic [ATAN_IDX_W-1:0] i);
		case (i)
			5'd0:    atan_q24 = 32'sd754974720;
			5'd1:    atan_q24 = 32'sd445687602;
			5'd2:    atan_q24 = 32'sd235489088;
			5'd3:    atan_q24 = 32'sd119537938;
			5'd4:    atan_q24 = 32'sd60000934;
			5'd5:    atan_q24 = 32'sd30029717;
			5'd6:    atan_q24 = 32'sd15018523;
			5'd7:    atan_q24 = 32'sd7509720;
			5'd8:    atan_q24 = 32'sd3754917;
			5'd9:    atan_q24 = 32'sd1877466;
			5'd10:   atan_q24 = 32'sd938734;
			5'd11:   atan_q24 = 32'sd469367;
			5'd12:   atan_q24 = 32'sd234684;
			5'd13:   atan_q24 = 32'sd117342;
			5'd14:   atan_q24 = 32'sd58671;
			5'd15:   atan_q24 = 32'sd29335;
			5'd16:   atan_q24 = 32'sd14668;
			5'd17:   atan_q24 = 32'sd7334;
			5'd18:   atan_q24 = 32'sd3667;
			5'd19:   atan_q24 = 32'sd1833;
			5'd20:   atan_q24 = 32'sd917;
			5'd21:   atan_q24 = 32'sd458;
			5'd22:   atan_q24 = 32'sd229;
			5'd23:   atan_q24 = 32'sd115;
			default: atan_q24 = 32'sd0;
		endcase
	endfunction

endpackage

/* src/mld_in_if.sv */
// Cursor position channel: valid/ready handshake with signed pixel coordinates.
// No dependencies.
interface mld_in_if #(parameter int POSITION_BITS = 24);
	logic                            valid;
	logic                            ready;
	logic signed [POSITION_BITS-1:0] cursor_x;
	logic signed [POSITION_BITS-1:0] cursor_y;

	modport source(output valid, output cursor_x, output cursor_y, input ready);
	modport sink(input valid, input cursor_x, input cursor_y, output ready);
endinterface

/* src/mld_out_if.sv */
// View direction channel: valid/ready handshake with direction vector and angles.
// No dependencies.
interface mld_out_if #(parameter int DIR_BITS = 16);
	logic                       valid;
	logic                       ready;
	logic signed [DIR_BITS-1:0] dir_x;
	logic signed [DIR_BITS-1:0] dir_y;
	logic signed [DIR_BITS-1:0] dir_z;
	logic signed [24:0]         yaw_now;
	logic signed [23:0]         pitch_now;

	modport source(output valid, output dir_x, output dir_y, output dir_z,
		output yaw_now, output pitch_now, input ready);
	modport sink(input valid, input dir_x, input dir_y, input dir_z,
		input yaw_now, input pitch_now, output ready);
endinterface

/* src/mld_ctrl.sv */
// Sequencer for mouse_look_direction: steps the datapath through one transaction.
// Depends on mld_pkg.
module mld_ctrl #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output mld_pkg::mld_cmd_t cmd
);
	import mld_pkg::*;

	localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	mld_state_t        state_q, state_d;
	logic [STEP_W-1:0] cnt_q;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.publish | (out_valid_q & ~out_ready);
			if (cmd.op == OP_CORDIC_YAW || cmd.op == OP_CORDIC_PITCH) begin
				cnt_q <= '0;
			end else if (cmd.op == OP_CORDIC_STEP) begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.step    = ATAN_IDX_W'(cnt_q);
		cmd.publish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_SCALE_X;
				end
			end
			ST_SCALE_X: begin
				cmd.op  = OP_SCALE_X;
				state_d = ST_SCALE_Y;
			end
			ST_SCALE_Y: begin
				cmd.op  = OP_SCALE_Y;
				state_d = ST_SAT_Y;
			end
			ST_SAT_Y: begin
				cmd.op  = OP_SAT_Y;
				state_d = ST_ANGLE;
			end
			ST_ANGLE: begin
				cmd.op  = OP_ANGLE;
				state_d = ST_YAW_INIT;
			end
			ST_YAW_INIT: begin
				cmd.op  = OP_CORDIC_YAW;
				state_d = ST_YAW_ITER;
			end
			ST_YAW_ITER: begin
				cmd.op = OP_CORDIC_STEP;
				if (cnt_q == LAST_STEP) begin
					state_d = ST_YAW_SAVE;
				end
			end
			ST_YAW_SAVE: begin
				cmd.op  = OP_SAVE_YAW;
				state_d = ST_PITCH_INIT;
			end
			ST_PITCH_INIT: begin
				cmd.op  = OP_CORDIC_PITCH;
				state_d = ST_PITCH_ITER;
			end
			ST_PITCH_ITER: begin
				cmd.op = OP_CORDIC_STEP;
				if (cnt_q == LAST_STEP) begin
					state_d = ST_PITCH_SAVE;
				end
			end
			ST_PITCH_SAVE: begin
				cmd.op  = OP_SAVE_PITCH;
				state_d = ST_MUL_X;
			end
			ST_MUL_X: begin
				cmd.op  = OP_MUL_X;
				state_d = ST_ROUND_X;
			end
			ST_ROUND_X: begin
				cmd.op  = OP_ROUND_X;
				state_d = ST_MUL_Z;
			end
			ST_MUL_Z: begin
				cmd.op  = OP_MUL_Z;
				state_d = ST_ROUND_Z;
			end
			ST_ROUND_Z: begin
				cmd.op  = OP_ROUND_Z;
				state_d = ST_ROUND_Y;
			end
			ST_ROUND_Y: begin
				cmd.op  = OP_ROUND_Y;
				state_d = ST_PUBLISH;
			end
			ST_PUBLISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

/* src/mld_datapath.sv */
// Datapath for mouse_look_direction: deltas, angle update, shared CORDIC, products.
// Depends on mld_pkg; driven by mld_ctrl commands.
module mld_datapath #(
	parameter int POSITION_BITS = 24,
	parameter int DIR_BITS      = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  mld_pkg::mld_cmd_t                     cmd,
	input  mld_pkg::mld_cfg_t                     cfg,
	input  logic signed [POSITION_BITS-1:0]       cursor_x,
	input  logic signed [POSITION_BITS-1:0]       cursor_y,
	output logic signed [DIR_BITS-1:0]            dir_x,
	output logic signed [DIR_BITS-1:0]            dir_y,
	output logic signed [DIR_BITS-1:0]            dir_z,
	output logic signed [mld_pkg::YAW_W-1:0]      yaw_now,
	output logic signed [mld_pkg::PITCH_W-1:0]    pitch_now
);
	import mld_pkg::*;

	localparam int D_W    = POSITION_BITS + 1;
	localparam int PROD_W = D_W + SENS_W + 1;
	localparam int DT_W   = 26;
	localparam int SUM_W  = 27;
	localparam int M_W    = 2 * XY_W;
	localparam int ZSH    = Z_FRAC - ANGLE_FRAC_BITS;
	localparam int RSH    = 2 * XY_FRAC - (DIR_BITS - 1);

	localparam logic signed [PROD_W-1:0] LIM_P   = PROD_W'(DEG360);
	localparam logic signed [SUM_W-1:0]  FULL_S  = SUM_W'(DEG360);
	localparam logic signed [SUM_W-1:0]  HALF_S  = SUM_W'(DEG180);
	localparam logic signed [SUM_W-1:0]  DEG90_S = SUM_W'(DEG90);
	localparam logic [M_W-1:0]           RND_HALF = M_W'(1) << (RSH - 1);
	localparam logic [M_W-1:0]           TOP      = M_W'(1) << (DIR_BITS - 1);

	// architectural state
	logic                             first_q;
	logic signed [POSITION_BITS-1:0]  prev_x_q, prev_y_q;
	logic signed [YAW_W-1:0]          yaw_q;
	logic signed [PITCH_W-1:0]        pitch_q;

	// working registers
	logic signed [D_W-1:0]     dx_q, dy_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [DT_W-1:0]    dyaw_q, dpitch_q;
	logic signed [SUM_W-1:0]   yaw_sum_q;
	logic signed [XY_W-1:0]    x_q, y_q;
	logic signed [Z_W-1:0]     z_q;
	logic                      flip_q;
	logic signed [XY_W-1:0]    cy_q, sy_q, cp_q, sp_q;
	logic signed [M_W-1:0]     mprod_q;
	logic signed [DIR_BITS-1:0] dx_dir_q, dy_dir_q, dz_dir_q;
	logic signed [DIR_BITS-1:0] dir_x_q, dir_y_q, dir_z_q;
	logic signed [YAW_W-1:0]    yaw_out_q;
	logic signed [PITCH_W-1:0]  pitch_out_q;

	// delta scaling
	logic signed [D_W-1:0]    mul_d;
	logic signed [SENS_W:0]   sens_s;
	logic signed [PROD_W-1:0] scaled;
	logic signed [PROD_W-1:0] sat_p;
	logic signed [DT_W-1:0]   sat_d;

	assign mul_d  = (cmd.op == OP_SCALE_Y) ? dy_q : dx_q;
	assign sens_s = $signed({1'b0, cfg.sensitivity});
	assign scaled = PROD_W'(mul_d) * PROD_W'(sens_s);

	always_comb begin
		if (prod_q > LIM_P) begin
			sat_p = LIM_P;
		end else if (prod_q < -LIM_P) begin
			sat_p = -LIM_P;
		end else begin
			sat_p = prod_q;
		end
		sat_d = DT_W'(sat_p);
	end

	// angle update: yaw wrap and pitch clamp
	logic signed [SUM_W-1:0]  yaw_wrap, pitch_sum, lim_raw, lim_s, pitch_clamp;
	logic signed [YAW_W-1:0]  yaw_next;
	logic signed [PITCH_W-1:0] pitch_next;

	always_comb begin
		if (yaw_sum_q < 0) begin
			yaw_wrap = yaw_sum_q + FULL_S;
		end else if (yaw_sum_q >= FULL_S) begin
			yaw_wrap = yaw_sum_q - FULL_S;
		end else begin
			yaw_wrap = yaw_sum_q;
		end
		yaw_next = YAW_W'(yaw_wrap - HALF_S);

		lim_raw = SUM_W'($signed({1'b0, cfg.pitch_limit}));
		lim_s   = (lim_raw > DEG90_S) ? DEG90_S : lim_raw;
		pitch_sum = SUM_W'(pitch_q) + SUM_W'(dpitch_q);
		if (pitch_sum > lim_s) begin
			pitch_clamp = lim_s;
		end else if (pitch_sum < -lim_s) begin
			pitch_clamp = -lim_s;
		end else begin
			pitch_clamp = pitch_sum;
		end
		pitch_next = PITCH_W'(pitch_clamp);
	end

	// CORDIC setup and one micro-rotation
	logic signed [YAW_W-1:0] ang;
	logic signed [Z_W-1:0]   z_ext, z_init;
	logic                    flip_init;
	logic signed [XY_W-1:0]  x_sh, y_sh, x_nx, y_nx;
	logic signed [Z_W-1:0]   at_z, z_nx;

	always_comb begin
		ang   = (cmd.op == OP_CORDIC_PITCH) ? YAW_W'(pitch_q) : yaw_q;
		z_ext = Z_W'(ang) <<< ZSH;
		if (z_ext > NINETY_Z) begin
			z_init    = z_ext - (NINETY_Z <<< 1);
			flip_init = 1'b1;
		end else if (z_ext < -NINETY_Z) begin
			z_init    = z_ext + (NINETY_Z <<< 1);
			flip_init = 1'b1;
		end else begin
			z_init    = z_ext;
			flip_init = 1'b0;
		end

		x_sh = x_q >>> cmd.step;
		y_sh = y_q >>> cmd.step;
		at_z = Z_W'(atan_q24(cmd.step));
		if (!z_q[Z_W-1]) begin
			x_nx = x_q - y_sh;
			y_nx = y_q + x_sh;
			z_nx = z_q - at_z;
		end else begin
			x_nx = x_q + y_sh;
			y_nx = y_q - x_sh;
			z_nx = z_q + at_z;
		end
	end

	// products and rounding to the output format
	logic signed [XY_W-1:0]     mul_a;
	logic signed [M_W-1:0]      mprod;
	logic signed [M_W-1:0]      rnd_in;
	logic [M_W-1:0]             rnd_mag, rnd_r, rnd_sat;
	logic signed [DIR_BITS-1:0] rnd_val;

	assign mul_a = (cmd.op == OP_MUL_Z) ? sy_q : cy_q;
	assign mprod = M_W'(mul_a) * M_W'(cp_q);

	always_comb begin
		if (cmd.op == OP_ROUND_Y) begin
			rnd_in = {{(M_W - XY_W - XY_FRAC){sp_q[XY_W-1]}}, sp_q, {XY_FRAC{1'b0}}};
		end else begin
			rnd_in = mprod_q;
		end
		rnd_mag = rnd_in[M_W-1] ? M_W'(-rnd_in) : M_W'(rnd_in);
		rnd_r   = (rnd_mag + RND_HALF) >> RSH;
		if (rnd_in[M_W-1]) begin
			rnd_sat = (rnd_r > TOP) ? TOP : rnd_r;
			rnd_val = DIR_BITS'(-rnd_sat);
		end else begin
			rnd_sat = (rnd_r > TOP - M_W'(1)) ? TOP - M_W'(1) : rnd_r;
			rnd_val = DIR_BITS'(rnd_sat);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= 1'b1;
			prev_x_q <= '0;
			prev_y_q <= '0;
			yaw_q    <= YAW_W'(YAW_RESET);
			pitch_q  <= '0;
		end else begin
			case (cmd.op)
				OP_LOAD: begin
					first_q  <= 1'b0;
					prev_x_q <= cursor_x;
					prev_y_q <= cursor_y;
				end
				OP_ANGLE: begin
					yaw_q   <= yaw_next;
					pitch_q <= pitch_next;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				if (first_q) begin
					dx_q <= '0;
					dy_q <= '0;
				end else begin
					dx_q <= D_W'(cursor_x) - D_W'(prev_x_q);
					dy_q <= D_W'(prev_y_q) - D_W'(cursor_y);
				end
			end
			OP_SCALE_X: begin
				prod_q <= scaled;
			end
			OP_SCALE_Y: begin
				prod_q <= scaled;
				dyaw_q <= sat_d;
			end
			OP_SAT_Y: begin
				dpitch_q  <= sat_d;
				yaw_sum_q <= SUM_W'(yaw_q) + HALF_S + SUM_W'(dyaw_q);
			end
			OP_CORDIC_YAW, OP_CORDIC_PITCH: begin
				x_q    <= CORDIC_INV_GAIN;
				y_q    <= '0;
				z_q    <= z_init;
				flip_q <= flip_init;
			end
			OP_CORDIC_STEP: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= z_nx;
			end
			OP_SAVE_YAW: begin
				cy_q <= flip_q ? -x_q : x_q;
				sy_q <= flip_q ? -y_q : y_q;
			end
			OP_SAVE_PITCH: begin
				cp_q <= flip_q ? -x_q : x_q;
				sp_q <= flip_q ? -y_q : y_q;
			end
			OP_MUL_X, OP_MUL_Z: begin
				mprod_q <= mprod;
			end
			OP_ROUND_X: begin
				dx_dir_q <= rnd_val;
			end
			OP_ROUND_Y: begin
				dy_dir_q <= rnd_val;
			end
			OP_ROUND_Z: begin
				dz_dir_q <= rnd_val;
			end
			default: begin
			end
		endcase
		if (cmd.publish) begin
			dir_x_q     <= dx_dir_q;
			dir_y_q     <= dy_dir_q;
			dir_z_q     <= dz_dir_q;
			yaw_out_q   <= yaw_q;
			pitch_out_q <= pitch_q;
		end
	end

	assign dir_x     = dir_x_q;
	assign dir_y     = dir_y_q;
	assign dir_z     = dir_z_q;
	assign yaw_now   = yaw_out_q;
	assign pitch_now = pitch_out_q;

endmodule

/* src/mouse_look_direction.sv */
// Top level of mouse_look_direction: configuration registers, sequencer, datapath.
// Depends on mld_pkg, mld_in_if, mld_out_if, mld_ctrl, mld_datapath and the defines header.
`include "mouse_look_direction_defines.svh"

// Mouse-look camera. Each cursor transaction updates yaw (wrapped to [-180,180) degrees)
// and pitch (clamped to the pitch limit, at most 90 degrees) from the pixel deltas
// times the sensitivity; the first transaction after reset only latches the position.
// The result carries the unit view vector in Q1.(DIR_BITS-1) and both angles in Q16
// degrees. One transaction is handled at a time, through the single CORDIC unit that runs
// yaw and then pitch, one micro-rotation per cycle. A finished result waits in the
// output register while the next transaction is accepted, so a new transaction can
// be taken as soon as the previous one is published, later only when the previous
// result is still waiting at the output. Configuration takes effect on the next
// transaction and must be written only while the block is idle.
module mouse_look_direction #(
	parameter int POSITION_BITS = 24,
	parameter int CORDIC_STEPS  = 16,
	parameter int DIR_BITS      = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	mld_in_if.sink                             cursor,
	mld_out_if.source                          view,
	input  logic                               cfg_we,
	input  logic [mld_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mld_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mld_pkg::*;

	localparam logic signed [PITCH_W-1:0] PITCH_MAX = PITCH_W'(DEG90);
	localparam logic signed [YAW_W-1:0]   YAW_MIN   = YAW_W'(-DEG180);
	localparam logic signed [YAW_W-1:0]   YAW_MAX   = YAW_W'(DEG180 - 1);

	mld_cfg_t cfg_q;
	mld_cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensitivity <= SENS_W'(SENS_RESET);
			cfg_q.pitch_limit <= LIMIT_W'(LIMIT_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SENSITIVITY: cfg_q.sensitivity <= cfg_data[SENS_W-1:0];
				CFG_PITCH_LIMIT: cfg_q.pitch_limit <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mld_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cursor.valid),
		.in_ready (cursor.ready),
		.out_valid(view.valid),
		.out_ready(view.ready),
		.cmd      (cmd)
	);

	mld_datapath #(
		.POSITION_BITS(POSITION_BITS),
		.DIR_BITS     (DIR_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cfg      (cfg_q),
		.cursor_x (cursor.cursor_x),
		.cursor_y (cursor.cursor_y),
		.dir_x    (view.dir_x),
		.dir_y    (view.dir_y),
		.dir_z    (view.dir_z),
		.yaw_now  (view.yaw_now),
		.pitch_now(view.pitch_now)
	);

	`MLD_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, cursor.valid && cursor.ready, !cursor.ready)
	`MLD_ASSERT_IMP(a_pitch_range, clk, arst_n, view.valid, (view.pitch_now <= PITCH_MAX) && (view.pitch_now >= -PITCH_MAX))
	`MLD_ASSERT_IMP(a_yaw_range, clk, arst_n, view.valid, (view.yaw_now >= YAW_MIN) && (view.yaw_now <= YAW_MAX))

endmodule

/* bench/mouse_look_direction_test.sv */
// Self-checking bench for mouse_look_direction: cursor transactions in, view transactions out.
// Predicts yaw, pitch and the CORDIC view vector per transaction and compares every field.
// Depends on mld_pkg, mld_in_if, mld_out_if and the mouse_look_direction RTL.
`timescale 1ns / 1ps

module mouse_look_direction_test;
	import mld_pkg::*;

	localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] POS_MIN = 24'sh800000;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
	localparam longint CORDIC_GAIN_INV = 652032874;
	localparam int DIR_FRAC = 15;

	typedef struct {
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
		logic signed [24:0] yaw;
		logic signed [23:0] pitch;
	} view_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mld_in_if #(.POSITION_BITS(24)) cursor_ch ();
	mld_out_if #(.DIR_BITS(16)) view_ch ();

	mouse_look_direction dut (
		.clk(clk),
		.arst_n(arst_n),
		.cursor(cursor_ch),
		.view(view_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// atan(2^-i) in degrees, Q24
	longint arctan_q24 [16] = '{
		754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
		15018523, 7509720, 3754917, 1877466, 938734, 469367,
		234684, 117342, 58671, 29335
	};

	logic [15:0] sens_reg;
	logic [22:0] limit_reg;
	bit first_pending;
	longint prev_px, prev_py, yaw_q16, pitch_q16;

	view_t pending_views[$];
	logic signed [23:0] last_x, last_y;
	bit calm;
	int errors;

	function automatic longint clamp(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_away(input longint v, input int s);
		longint h;
		h = longint'(1) <<< (s - 1);
		return v < 0 ? -((-v + h) >>> s) : ((v + h) >>> s);
	endfunction

	function automatic longint scaled_delta(input longint d);
		return clamp(d * longint'(sens_reg), -longint'(DEG360), longint'(DEG360));
	endfunction

	function automatic void cordic_rot(input longint ang, output longint c, output longint s);
		longint z, x, y, nx, ninety;
		bit flip;
		int i;
		ninety = longint'(90) <<< 24;
		z = ang <<< 8;
		x = CORDIC_GAIN_INV;
		y = 0;
		flip = 1'b0;
		if (z > ninety) begin
			z -= 2 * ninety;
			flip = 1'b1;
		end else if (z < -ninety) begin
			z += 2 * ninety;
			flip = 1'b1;
		end
		for (i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= arctan_q24[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += arctan_q24[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic logic signed [15:0] to_q15(input longint q60);
		return 16'(clamp(round_away(q60, 60 - DIR_FRAC), -32768, 32767));
	endfunction

	function automatic void reset_predictor();
		sens_reg = 16'(SENS_RESET);
		limit_reg = 23'(LIMIT_RESET);
		first_pending = 1'b1;
		prev_px = 0;
		prev_py = 0;
		yaw_q16 = longint'(YAW_RESET);
		pitch_q16 = 0;
	endfunction

	function automatic view_t next_view(input logic signed [23:0] x, input logic signed [23:0] y);
		view_t v;
		longint px, py, t, lim, cy, sy, cp, sp;
		px = longint'(x);
		py = longint'(y);
		if (first_pending) begin
			prev_px = px;
			prev_py = py;
			first_pending = 1'b0;
		end
		yaw_q16 += scaled_delta(px - prev_px);
		pitch_q16 += scaled_delta(prev_py - py);
		prev_px = px;
		prev_py = py;
		t = (yaw_q16 + DEG180) % DEG360;
		if (t < 0)
			t += DEG360;
		yaw_q16 = t - DEG180;
		lim = longint'(limit_reg);
		if (lim > DEG90)
			lim = longint'(DEG90);
		pitch_q16 = clamp(pitch_q16, -lim, lim);
		cordic_rot(yaw_q16, cy, sy);
		cordic_rot(pitch_q16, cp, sp);
		v.dir_x = to_q15(cy * cp);
		v.dir_y = to_q15(sp <<< 30);
		v.dir_z = to_q15(sy * cp);
		v.yaw = yaw_q16[24:0];
		v.pitch = pitch_q16[23:0];
		return v;
	endfunction

	function automatic void compare_field(input string name, input logic signed [63:0] want,
		input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

	always @(posedge clk) begin
		view_ch.ready <= calm || ($urandom_range(99) >= 33);
	end

	always @(posedge clk) begin
		view_t want;
		if (arst_n && view_ch.valid && view_ch.ready) begin
			if (pending_views.size() == 0) begin
				$display("%0t unexpected view transaction: expected none, actual x %0d y %0d z %0d",
					$time, view_ch.dir_x, view_ch.dir_y, view_ch.dir_z);
				errors++;
			end else begin
				want = pending_views.pop_front();
				compare_field("dir_x", want.dir_x, view_ch.dir_x);
				compare_field("dir_y", want.dir_y, view_ch.dir_y);
				compare_field("dir_z", want.dir_z, view_ch.dir_z);
				compare_field("yaw_now", want.yaw, view_ch.yaw_now);
				compare_field("pitch_now", want.pitch, view_ch.pitch_now);
			end
		end
	end

	task automatic send_cursor(input logic signed [23:0] x, input logic signed [23:0] y);
		if (!calm && $urandom_range(99) < 33) begin
			cursor_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 64)) @(posedge clk);
		end
		cursor_ch.valid <= 1'b1;
		cursor_ch.cursor_x <= x;
		cursor_ch.cursor_y <= y;
		do @(posedge clk); while (!cursor_ch.ready);
		pending_views.push_back(next_view(x, y));
		last_x = x;
		last_y = y;
	endtask

	task automatic move_by(input int dx, input int dy);
		send_cursor(24'(last_x + dx), 24'(last_y + dy));
	endtask

	task automatic wait_for_results();
		cursor_ch.valid <= 1'b0;
		while (pending_views.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_SENSITIVITY: sens_reg = data[15:0];
			CFG_PITCH_LIMIT: limit_reg = data;
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [23:0] extreme_position();
		case ($urandom_range(3))
			0: return POS_MIN;
			1: return POS_MAX;
			2: return 24'sd0;
			default: return -24'sd1;
		endcase
	endfunction

	// first transaction only latches; a repeat of it must not move the view
	task automatic test_first_position();
		send_cursor(POS_MAX, POS_MIN);
		send_cursor(POS_MAX, POS_MIN);
	endtask

	// half a degree per pixel puts yaw exactly on the +-90 and +-180 boundaries
	task automatic test_yaw_wrap();
		wait_for_results();
		cfg_write(CFG_SENSITIVITY, 23'd32768);
		send_cursor(24'sd0, 24'sd0);
		move_by(360, 0);
		move_by(2, 0);
		move_by(178, 0);
		move_by(178, 0);
		move_by(2, 0);
	endtask

	task automatic test_pitch_clamp();
		move_by(0, -400);
		wait_for_results();
		cfg_write(CFG_PITCH_LIMIT, 23'h7FFFFF);
		move_by(0, -4);
		wait_for_results();
		cfg_write(CFG_PITCH_LIMIT, 23'd0);
		move_by(0, 0);
		wait_for_results();
		cfg_write(CFG_PITCH_LIMIT, 23'(DEG90));
		move_by(0, 400);
	endtask

	// full-scale jumps at top sensitivity hit the 360 degree delta limit
	task automatic test_delta_saturation();
		wait_for_results();
		cfg_write(CFG_SENSITIVITY, 23'h7FFFFF);
		cfg_write(CFG_SPARE_LO, 23'd0);
		cfg_write(CFG_SPARE_HI, 23'h7FFFFF);
		send_cursor(POS_MIN, POS_MAX);
		send_cursor(POS_MAX, POS_MIN);
		move_by(-1, 1);
		move_by(0, 0);
	endtask

	task automatic test_sensitivity_ends();
		wait_for_results();
		cfg_write(CFG_SENSITIVITY, 23'd0);
		move_by(1000, -1000);
		send_cursor(24'sd0, -24'sd1);
		wait_for_results();
		cfg_write(CFG_SENSITIVITY, 23'd1);
		cfg_write(CFG_PITCH_LIMIT, 23'(LIMIT_RESET));
		move_by(12345, -6789);
	endtask

	task automatic test_random_motion(input logic [15:0] sens, input logic [22:0] limit,
		input int count, input bit no_idle);
		logic signed [23:0] step_x, step_y;
		int pick;
		wait_for_results();
		cfg_write(CFG_SENSITIVITY, 23'(sens));
		cfg_write(CFG_PITCH_LIMIT, limit);
		calm = no_idle;
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 2)
				wait_for_results();
			if (pick < 60) begin
				step_x = 24'($urandom_range(400) - 200);
				step_y = 24'($urandom_range(400) - 200);
				send_cursor(last_x + step_x, last_y + step_y);
			end else if (pick < 80) begin
				step_x = 24'($urandom_range(40000) - 20000);
				step_y = 24'($urandom_range(40000) - 20000);
				send_cursor(last_x + step_x, last_y + step_y);
			end else if (pick < 93) begin
				send_cursor(24'($urandom), 24'($urandom));
			end else begin
				send_cursor(extreme_position(), extreme_position());
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cursor_ch.valid <= 1'b0;
		cursor_ch.cursor_x <= '0;
		cursor_ch.cursor_y <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		calm = 1'b0;
		errors = 0;
		last_x = '0;
		last_y = '0;
		reset_predictor();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_position();
		test_yaw_wrap();
		test_pitch_clamp();
		test_delta_saturation();
		test_sensitivity_ends();

		test_random_motion(16'(SENS_RESET), 23'(LIMIT_RESET), 170, 1'b0);
		test_random_motion(16'($urandom), 23'($urandom), 170, 1'b0);
		test_random_motion(16'hFFFF, 23'(DEG90), 170, 1'b1);
		test_random_motion(16'd1, 23'd0, 170, 1'b0);
		test_random_motion(16'($urandom_range(200, 20000)), 23'($urandom_range(DEG90)), 170, 1'b0);

		wait_for_results();
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
